### sv/vehicle_light_level_controller_unit_assert.svh
// assertion macros for the vehicle light level controller
`ifndef VEHICLE_LIGHT_LEVEL_CONTROLLER_UNIT_ASSERT_SVH
`define VEHICLE_LIGHT_LEVEL_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication on clk_i, off during reset
`define VLLC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vllc check failed");

// next-cycle implication on clk_i, off during reset
`define VLLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vllc check failed");

`endif

### sv/vllc_pkg.sv
// shared types and constants of the vehicle light level controller
`timescale 1ns / 1ps
`default_nettype none

package vllc_pkg;

  localparam int unsigned NUM_LAMPS            = 4;
  localparam int unsigned LEVEL_W              = 8;
  localparam int unsigned STICK_SPAN           = 100;
  localparam int unsigned BREATH_PERIOD_MS_DEF = 1000;

  typedef enum logic [2:0] {
    MODE_OFF       = 3'd0,
    MODE_STEER_MIX = 3'd1,
    MODE_THROTTLE  = 3'd2,
    MODE_BREATH    = 3'd3,
    MODE_ALL_LOW   = 3'd4,
    MODE_ALL_HIGH  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    CFG_MODE        = 3'd0,
    CFG_THRESHOLD   = 3'd1,
    CFG_FADE_STEP   = 3'd2,
    CFG_LOW_LEVELS  = 3'd3,
    CFG_HIGH_LEVELS = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CLS_IDLE = 2'd0,
    CLS_POS  = 2'd1,
    CLS_NEG  = 2'd2
  } cls_e;

  typedef struct packed {
    logic tgt_en;
    logic lvl_en;
    logic breath;
  } lamp_ctl_t;

endpackage

`default_nettype wire

### sv/vehicle_light_level_controller_unit.sv
// top level of the vehicle light level controller
// Takes one control tick per beat and returns the four faded lamp levels for it.
// A new tick is taken every clock cycle unless a stalled output holds input back,
// which it does only once all four stages are full: input register, stick classing
// and remap multiply, constant divide by reciprocal multiply in each lamp, fade
// into the level register. Stick classes, breathing timer and lamp levels are
// carried from tick to tick. The user must write configuration through the cfg
// port while no tick is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module vehicle_light_level_controller_unit #(
  parameter int unsigned BreathPeriodMs = vllc_pkg::BREATH_PERIOD_MS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // steer_position [7:0], throttle_position [15:8], time_ms [47:16]
  input  logic [47:0] s_axis_tdata,
  // steer_present [0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // front_left [7:0], rear_left [15:8], rear_right [23:16], front_right [31:24]
  output logic [31:0] m_axis_tdata
);
  import vllc_pkg::*;

  `include "vehicle_light_level_controller_unit_assert.svh"

  localparam int unsigned DiffW = $clog2(BreathPeriodMs + 1);
  localparam int unsigned XW    = (DiffW + 1 > 10) ? DiffW + 1 : 10;
  localparam int unsigned ProdW = XW + 9;
  localparam int unsigned FL    = 0;
  localparam int unsigned RL    = 1;
  localparam int unsigned RR    = 2;
  localparam int unsigned FR    = 3;

  // configuration
  logic [2:0]           mode_q;
  logic [6:0]           thr_q;
  logic [LEVEL_W-1:0]   fade_step_q;
  logic [31:0]          low_levels_q, high_levels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_STEER_MIX;
      thr_q         <= 7'd10;
      fade_step_q   <= 8'd5;
      low_levels_q  <= '0;
      high_levels_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:        mode_q        <= cfg_wdata_i[2:0];
        CFG_THRESHOLD:   thr_q         <= cfg_wdata_i[6:0];
        CFG_FADE_STEP:   fade_step_q   <= cfg_wdata_i[7:0];
        CFG_LOW_LEVELS:  low_levels_q  <= cfg_wdata_i;
        CFG_HIGH_LEVELS: high_levels_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic v0_q, v1_q, v2_q, v3_q;
  logic ready0, ready1, ready2, ready3;
  logic move0, move1, move2, move3;

  assign ready3 = !v3_q || m_axis_tready;
  assign ready2 = !v2_q || ready3;
  assign ready1 = !v1_q || ready2;
  assign ready0 = !v0_q || ready1;
  assign move0  = s_axis_tvalid && ready0;
  assign move1  = v0_q && ready1;
  assign move2  = v1_q && ready2;
  assign move3  = v2_q && ready3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready0) v0_q <= s_axis_tvalid;
      if (ready1) v1_q <= v0_q;
      if (ready2) v2_q <= v1_q;
      if (ready3) v3_q <= v2_q;
    end
  end

  assign s_axis_tready = ready0;
  assign m_axis_tvalid = v3_q;

  // input register
  logic signed [7:0] steer_q, throttle_q;
  logic              present_q;
  logic [31:0]       now_q;

  always_ff @(posedge clk_i) begin
    if (move0) begin
      steer_q    <= s_axis_tdata[7:0];
      throttle_q <= s_axis_tdata[15:8];
      now_q      <= s_axis_tdata[47:16];
      present_q  <= s_axis_tuser;
    end
  end

  // stick classing, reclassed only when the position moves
  logic signed [7:0] steer_prev_q, throttle_prev_q;
  cls_e              steer_cls_q, throttle_cls_q, steer_cls_d, throttle_cls_d;
  logic signed [8:0] thr_s, steer9, throttle9;

  assign thr_s     = $signed({2'b00, thr_q});
  assign steer9    = 9'(steer_q);
  assign throttle9 = 9'(throttle_q);

  always_comb begin
    steer_cls_d = steer_cls_q;
    if (steer_q != steer_prev_q) begin
      steer_cls_d = CLS_IDLE;
      if (steer9 > thr_s)  steer_cls_d = CLS_POS;
      if (steer9 < -thr_s) steer_cls_d = CLS_NEG;
    end
    throttle_cls_d = throttle_cls_q;
    if (throttle_q != throttle_prev_q) begin
      throttle_cls_d = CLS_IDLE;
      if (throttle9 > thr_s)  throttle_cls_d = CLS_POS;
      if (throttle9 < -thr_s) throttle_cls_d = CLS_NEG;
    end
  end

  // breathing timer
  logic        breath_started_q, breath_falling_q;
  logic [31:0] breath_start_q;
  logic [31:0] b_start, b_start_d, elapsed;
  logic        b_fall, b_fall_d, b_flip;
  logic [DiffW-1:0] b_diff;

  always_comb begin
    b_start   = breath_started_q ? breath_start_q : now_q;
    b_fall    = breath_started_q ? breath_falling_q : 1'b0;
    elapsed   = now_q - b_start;
    b_flip    = elapsed > 32'(BreathPeriodMs);
    b_start_d = b_flip ? now_q : b_start;
    b_fall_d  = b_fall ^ b_flip;
    b_diff    = b_flip ? '0 : elapsed[DiffW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steer_prev_q     <= '0;
      throttle_prev_q  <= '0;
      steer_cls_q      <= CLS_IDLE;
      throttle_cls_q   <= CLS_IDLE;
      breath_started_q <= 1'b0;
      breath_falling_q <= 1'b0;
      breath_start_q   <= '0;
    end else if (move1) begin
      steer_prev_q    <= steer_q;
      throttle_prev_q <= throttle_q;
      steer_cls_q     <= steer_cls_d;
      throttle_cls_q  <= throttle_cls_d;
      if (mode_q == MODE_BREATH) begin
        breath_started_q <= 1'b1;
        breath_falling_q <= b_fall_d;
        breath_start_q   <= b_start_d;
      end
    end
  end

  // remap terms: target = x * y / divisor + c
  logic [LEVEL_W-1:0]     lo_lvl [NUM_LAMPS];
  logic [LEVEL_W-1:0]     hi_lvl [NUM_LAMPS];
  logic signed [9:0]      lo10 [NUM_LAMPS];
  logic signed [9:0]      hi10 [NUM_LAMPS];
  logic signed [9:0]      s10, t10, s_off, t_off;
  logic signed [XW-1:0]   x_c [NUM_LAMPS];
  logic signed [9:0]      y_c [NUM_LAMPS];
  logic signed [8:0]      c_c [NUM_LAMPS];
  logic signed [XW+9:0]   prod_full [NUM_LAMPS];

  assign s10   = 10'(steer_q);
  assign t10   = 10'(throttle_q);
  assign s_off = s10 + 10'sd100;
  assign t_off = t10 + 10'sd100;

  always_comb begin
    for (int i = 0; i < NUM_LAMPS; i++) begin
      lo_lvl[i] = low_levels_q[LEVEL_W*i +: LEVEL_W];
      hi_lvl[i] = high_levels_q[LEVEL_W*i +: LEVEL_W];
      lo10[i]   = $signed({2'b00, lo_lvl[i]});
      hi10[i]   = $signed({2'b00, hi_lvl[i]});
      x_c[i]    = '0;
      y_c[i]    = '0;
      c_c[i]    = $signed({1'b0, lo_lvl[i]});
    end
    case (mode_q)
      MODE_STEER_MIX, MODE_THROTTLE: begin
        if (mode_q == MODE_STEER_MIX && present_q) begin
          if (throttle_cls_d == CLS_POS) begin
            if (steer_cls_d == CLS_POS) begin
              x_c[FL] = XW'(t10);
              y_c[FL] = hi10[FL] - lo10[FL];
              x_c[FR] = XW'(s10);
              y_c[FR] = hi10[FR] - t10;
              c_c[FR] = throttle9;
            end else if (steer_cls_d == CLS_NEG) begin
              x_c[FL] = XW'(s_off);
              y_c[FL] = t10 - hi10[FL];
              c_c[FL] = $signed({1'b0, hi_lvl[FL]});
              x_c[FR] = XW'(t10);
              y_c[FR] = hi10[FR] - lo10[FR];
            end else begin
              x_c[FL] = XW'(t10);
              y_c[FL] = hi10[FL] - lo10[FL];
              x_c[FR] = XW'(t10);
              y_c[FR] = hi10[FR] - lo10[FR];
            end
          end else begin
            if (steer_cls_d == CLS_POS) begin
              x_c[FR] = XW'(s10);
              y_c[FR] = hi10[FR] - lo10[FR];
            end else if (steer_cls_d == CLS_NEG) begin
              x_c[FL] = XW'(s_off);
              y_c[FL] = lo10[FL] - hi10[FL];
              c_c[FL] = $signed({1'b0, hi_lvl[FL]});
            end
            if (throttle_cls_d == CLS_NEG) begin
              x_c[RL] = XW'(t_off);
              y_c[RL] = lo10[RL] - hi10[RL];
              c_c[RL] = $signed({1'b0, hi_lvl[RL]});
              x_c[RR] = XW'(t_off);
              y_c[RR] = lo10[RR] - hi10[RR];
              c_c[RR] = $signed({1'b0, hi_lvl[RR]});
            end
          end
        end else begin
          if (throttle_cls_d == CLS_POS) begin
            x_c[FL] = XW'(t10);
            y_c[FL] = hi10[FL] - lo10[FL];
            x_c[FR] = XW'(t10);
            y_c[FR] = hi10[FR] - lo10[FR];
          end else if (throttle_cls_d == CLS_NEG) begin
            x_c[RL] = XW'(t_off);
            y_c[RL] = lo10[RL] - hi10[RL];
            c_c[RL] = $signed({1'b0, hi_lvl[RL]});
            x_c[RR] = XW'(t_off);
            y_c[RR] = lo10[RR] - hi10[RR];
            c_c[RR] = $signed({1'b0, hi_lvl[RR]});
          end
        end
      end
      MODE_BREATH: begin
        for (int i = 0; i < NUM_LAMPS; i++) begin
          x_c[i] = XW'(b_diff);
          if (b_fall_d) begin
            y_c[i] = lo10[i] - hi10[i];
            c_c[i] = $signed({1'b0, hi_lvl[i]});
          end else begin
            y_c[i] = hi10[i] - lo10[i];
          end
        end
      end
      MODE_ALL_LOW: ;
      MODE_ALL_HIGH: begin
        for (int i = 0; i < NUM_LAMPS; i++) begin
          c_c[i] = $signed({1'b0, hi_lvl[i]});
        end
      end
      default: begin
        for (int i = 0; i < NUM_LAMPS; i++) begin
          c_c[i] = '0;
        end
      end
    endcase
    for (int i = 0; i < NUM_LAMPS; i++) begin
      prod_full[i] = x_c[i] * y_c[i];
    end
  end

  // product register
  logic signed [ProdW-1:0] prod_q [NUM_LAMPS];
  logic signed [8:0]       c_q [NUM_LAMPS];
  logic                    breath_q;

  always_ff @(posedge clk_i) begin
    if (move1) begin
      for (int i = 0; i < NUM_LAMPS; i++) begin
        prod_q[i] <= prod_full[i][ProdW-1:0];
        c_q[i]    <= c_c[i];
      end
      breath_q <= (mode_q == MODE_BREATH);
    end
  end

  // lamps
  lamp_ctl_t          lamp_ctl;
  logic [LEVEL_W-1:0] level [NUM_LAMPS];

  assign lamp_ctl.tgt_en = move2;
  assign lamp_ctl.lvl_en = move3;
  assign lamp_ctl.breath = breath_q;

  for (genvar g = 0; g < NUM_LAMPS; g++) begin : g_lamp
    vllc_lamp #(
      .BreathPeriodMs(BreathPeriodMs),
      .ProdW         (ProdW)
    ) u_lamp (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (lamp_ctl),
      .prod_i      (prod_q[g]),
      .offset_i    (c_q[g]),
      .fade_step_i (fade_step_q),
      .high_level_i(high_levels_q[LEVEL_W*g +: LEVEL_W]),
      .level_o     (level[g])
    );
  end

  assign m_axis_tdata = {level[FR], level[RR], level[RL], level[FL]};

  `VLLC_ASSERT_NEXT(a_stage2_holds, v2_q && !ready3, v2_q)
  `VLLC_ASSERT_NOW(a_full_blocks, v0_q && v1_q && v2_q && v3_q && !m_axis_tready, !s_axis_tready)
  `VLLC_ASSERT_NEXT(a_result_follows, move3, m_axis_tvalid)
  `VLLC_ASSERT_NEXT(a_breath_sticky, breath_started_q, breath_started_q)

endmodule

`default_nettype wire

### sv/vllc_lamp.sv
// one lamp: constant divide of the remap product, then fade of the stored level
`timescale 1ns / 1ps
`default_nettype none

module vllc_lamp #(
  parameter int unsigned BreathPeriodMs = vllc_pkg::BREATH_PERIOD_MS_DEF,
  parameter int unsigned ProdW          = 19
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vllc_pkg::lamp_ctl_t         ctl_i,
  input  logic signed [ProdW-1:0]     prod_i,
  input  logic signed [8:0]           offset_i,
  input  logic [vllc_pkg::LEVEL_W-1:0] fade_step_i,
  input  logic [vllc_pkg::LEVEL_W-1:0] high_level_i,
  output logic [vllc_pkg::LEVEL_W-1:0] level_o
);
  import vllc_pkg::*;

  localparam int unsigned MagW        = ProdW - 1;
  localparam int unsigned RecW        = MagW + 1;
  localparam int unsigned MulW        = 2 * MagW + 1;
  localparam int unsigned QuotW       = 10;
  localparam int unsigned ShiftSpan   = MagW + $clog2(STICK_SPAN);
  localparam int unsigned ShiftBreath = MagW + $clog2(BreathPeriodMs);
  localparam longint unsigned RecSpan =
    ((64'd1 << ShiftSpan) + STICK_SPAN - 1) / STICK_SPAN;
  localparam longint unsigned RecBreath =
    ((64'd1 << ShiftBreath) + BreathPeriodMs - 1) / BreathPeriodMs;

  logic [MagW:0]             neg_prod;
  logic [MagW-1:0]           mag;
  logic [RecW-1:0]           rec;
  logic [MulW-1:0]           mul;
  logic [QuotW-1:0]          quot;
  logic signed [QuotW:0]     quot_s;
  logic signed [11:0]        tgt_d, tgt_q;
  logic [LEVEL_W:0]          up_sum;
  logic [LEVEL_W-1:0]        up_lvl, level_d, level_q;

  // truncating signed divide by reciprocal multiply on the magnitude
  assign neg_prod = -prod_i;
  assign mag      = prod_i[MagW] ? neg_prod[MagW-1:0] : prod_i[MagW-1:0];
  assign rec      = ctl_i.breath ? RecW'(RecBreath) : RecW'(RecSpan);
  assign mul      = MulW'(mag) * MulW'(rec);
  assign quot     = ctl_i.breath ? mul[ShiftBreath +: QuotW] : mul[ShiftSpan +: QuotW];
  assign quot_s   = prod_i[MagW] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign tgt_d    = 12'(quot_s) + 12'(offset_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.tgt_en) begin
      tgt_q <= tgt_d;
    end
  end

  // fade up with cap, then fade down with floor, both in one tick
  always_comb begin
    up_sum = {1'b0, level_q} + {1'b0, fade_step_i};
    up_lvl = level_q;
    if (tgt_q > $signed({4'b0000, level_q})) begin
      up_lvl = (up_sum > {1'b0, high_level_i}) ? high_level_i : up_sum[LEVEL_W-1:0];
    end
    level_d = up_lvl;
    if (tgt_q < $signed({4'b0000, up_lvl})) begin
      level_d = (up_lvl < fade_step_i) ? '0 : up_lvl - fade_step_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (ctl_i.lvl_en) begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule

`default_nettype wire

### sim/tb_vehicle_light_level_controller_unit.sv
// self-checking testbench of the vehicle light level controller: directed and random ticks against a predictor
`timescale 1ns / 1ps

module tb_vehicle_light_level_controller_unit;
  import vllc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int NUM_PHASES   = 30;
  localparam int PHASE_TICKS  = 55;

  typedef struct packed {
    logic [7:0]  steer;
    logic [7:0]  throttle;
    logic        present;
    logic [31:0] ms;
  } tick_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // steer_position [7:0], throttle_position [15:8], time_ms [47:16]
  logic [47:0] s_axis_tdata = '0;
  // steer_present [0]
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // front_left [7:0], rear_left [15:8], rear_right [23:16], front_right [31:24]
  logic [31:0] m_axis_tdata;

  vehicle_light_level_controller_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // register copies
  logic [2:0]  cfg_mode = MODE_STEER_MIX;
  int          cfg_thresh = 10;
  int          cfg_step = 5;
  logic [31:0] cfg_low = 32'h0;
  logic [31:0] cfg_high = 32'hFFFF_FFFF;

  // lamp state
  logic [7:0]  lamp_lvl [NUM_LAMPS] = '{default: 8'h00};
  logic [31:0] breath_t0 = '0;
  bit          breath_down = 1'b0;
  bit          breath_on = 1'b0;
  int          steer_last = 0;
  int          thr_last = 0;
  cls_e        steer_cls = CLS_IDLE;
  cls_e        thr_cls = CLS_IDLE;

  tick_t       ticks_pending_q [$];
  logic [31:0] lamps_expected_q [$];
  int          errors = 0;
  int          cycles = 0;
  bit          in_fire_q = 1'b0;
  bit          out_fire_q = 1'b0;
  int          gap_left = 0;
  bit          send_calm = 1'b0;
  int          stall_left = 0;
  bit          recv_calm = 1'b0;

  // stimulus generator state
  int          gen_steer = 0;
  int          gen_thr = 0;
  logic [31:0] gen_ms = '0;

  string lamp_name [NUM_LAMPS] = '{"front_left", "rear_left", "rear_right", "front_right"};

  function automatic int remap(int x, int a, int b, int c, int d);
    return (x - a) * (d - c) / (b - a) + c;
  endfunction

  function automatic logic [31:0] advance_lamps(tick_t tk);
    int          s;
    int          t;
    int          lo [NUM_LAMPS];
    int          hi [NUM_LAMPS];
    int          tg [NUM_LAMPS];
    int          cur;
    logic [31:0] el;
    logic [31:0] res;
    s = $signed(tk.steer);
    t = $signed(tk.throttle);
    for (int i = 0; i < NUM_LAMPS; i++) begin
      lo[i] = cfg_low[8*i +: 8];
      hi[i] = cfg_high[8*i +: 8];
      tg[i] = lo[i];
    end
    // a stick is only reclassed when its position moves
    if (s != steer_last) begin
      steer_cls = CLS_IDLE;
      if (s > cfg_thresh) steer_cls = CLS_POS;
      if (s < -cfg_thresh) steer_cls = CLS_NEG;
    end
    steer_last = s;
    if (t != thr_last) begin
      thr_cls = CLS_IDLE;
      if (t > cfg_thresh) thr_cls = CLS_POS;
      if (t < -cfg_thresh) thr_cls = CLS_NEG;
    end
    thr_last = t;

    if (cfg_mode == MODE_STEER_MIX && tk.present) begin
      if (thr_cls == CLS_POS) begin
        if (steer_cls == CLS_POS) begin
          tg[0] = remap(t, 0, 100, lo[0], hi[0]);
          tg[3] = remap(s, 0, 100, t, hi[3]);
        end else if (steer_cls == CLS_NEG) begin
          tg[0] = remap(s, -100, 0, hi[0], t);
          tg[3] = remap(t, 0, 100, lo[3], hi[3]);
        end else begin
          tg[0] = remap(t, 0, 100, lo[0], hi[0]);
          tg[3] = remap(t, 0, 100, lo[3], hi[3]);
        end
      end else begin
        if (steer_cls == CLS_POS) tg[3] = remap(s, 0, 100, lo[3], hi[3]);
        else if (steer_cls == CLS_NEG) tg[0] = remap(s, -100, 0, hi[0], lo[0]);
        if (thr_cls == CLS_NEG) begin
          tg[1] = remap(t, -100, 0, hi[1], lo[1]);
          tg[2] = remap(t, -100, 0, hi[2], lo[2]);
        end
      end
    end else if (cfg_mode == MODE_STEER_MIX || cfg_mode == MODE_THROTTLE) begin
      if (thr_cls == CLS_POS) begin
        tg[0] = remap(t, 0, 100, lo[0], hi[0]);
        tg[3] = remap(t, 0, 100, lo[3], hi[3]);
      end else if (thr_cls == CLS_NEG) begin
        tg[1] = remap(t, -100, 0, hi[1], lo[1]);
        tg[2] = remap(t, -100, 0, hi[2], lo[2]);
      end
    end else if (cfg_mode == MODE_BREATH) begin
      if (!breath_on) begin
        breath_on = 1'b1;
        breath_t0 = tk.ms;
        breath_down = 1'b0;
      end
      el = tk.ms - breath_t0;
      if (el > BREATH_PERIOD_MS_DEF) begin
        breath_t0 = tk.ms;
        breath_down = !breath_down;
      end
      el = tk.ms - breath_t0;
      if (el > BREATH_PERIOD_MS_DEF) el = BREATH_PERIOD_MS_DEF;
      for (int i = 0; i < NUM_LAMPS; i++) begin
        if (breath_down) tg[i] = remap(int'(el), 0, BREATH_PERIOD_MS_DEF, hi[i], lo[i]);
        else tg[i] = remap(int'(el), 0, BREATH_PERIOD_MS_DEF, lo[i], hi[i]);
      end
    end else if (cfg_mode == MODE_ALL_LOW) begin
      // targets stay at the weak levels
    end else if (cfg_mode == MODE_ALL_HIGH) begin
      for (int i = 0; i < NUM_LAMPS; i++) tg[i] = hi[i];
    end else begin
      for (int i = 0; i < NUM_LAMPS; i++) tg[i] = 0;
    end

    // rise then fall in the same tick
    for (int i = 0; i < NUM_LAMPS; i++) begin
      cur = lamp_lvl[i];
      if (tg[i] > cur) begin
        cur = cur + cfg_step;
        if (cur > hi[i]) cur = hi[i];
      end
      if (tg[i] < cur) begin
        cur = cur - cfg_step;
        if (cur < 0) cur = 0;
      end
      lamp_lvl[i] = cur[7:0];
      res[8*i +: 8] = cur[7:0];
    end
    return res;
  endfunction

  // input beats are predicted, output beats are checked
  always @(posedge clk_i) begin
    tick_t       tk;
    logic [31:0] exp_lamps;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("vehicle_light_level_controller_unit: mismatch");
      $finish;
    end
    in_fire_q <= rst_ni && s_axis_tvalid && s_axis_tready;
    out_fire_q <= rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (lamps_expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: %h", m_axis_tdata);
      end else begin
        exp_lamps = lamps_expected_q.pop_front();
        for (int i = 0; i < NUM_LAMPS; i++) begin
          if (m_axis_tdata[8*i +: 8] !== exp_lamps[8*i +: 8]) begin
            errors++;
            if (errors <= 10)
              $display("%s level: expected %0d, got %0d", lamp_name[i],
                       exp_lamps[8*i +: 8], m_axis_tdata[8*i +: 8]);
          end
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      tk.steer    = s_axis_tdata[7:0];
      tk.throttle = s_axis_tdata[15:8];
      tk.ms       = s_axis_tdata[47:16];
      tk.present  = s_axis_tuser;
      lamps_expected_q.push_back(advance_lamps(tk));
    end
  end

  // tick driver
  always @(negedge clk_i) begin
    tick_t tk;
    if (rst_ni && (!s_axis_tvalid || in_fire_q)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (ticks_pending_q.size() > 0) begin
        tk = ticks_pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tk.ms, tk.throttle, tk.steer};
        s_axis_tuser  <= tk.present;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        gap_left = send_calm ? 0 : $urandom_range(0, 11);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink with random stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire_q) begin
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        stall_left = recv_calm ? 0 : $urandom_range(0, 11);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_MODE:        cfg_mode = val[2:0];
      CFG_THRESHOLD:   cfg_thresh = val[6:0];
      CFG_FADE_STEP:   cfg_step = val[7:0];
      CFG_LOW_LEVELS:  cfg_low = val;
      CFG_HIGH_LEVELS: cfg_high = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_tick(int s, int t, bit p, logic [31:0] ms);
    tick_t tk;
    tk.steer    = s[7:0];
    tk.throttle = t[7:0];
    tk.present  = p;
    tk.ms       = ms;
    ticks_pending_q.push_back(tk);
  endtask

  function automatic int next_stick(int prev);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 25) return prev;
    if (r < 70) return $urandom_range(0, 200) - 100;
    if (r < 80) return $urandom_range(0, 255) - 128;
    // hug the threshold
    v = cfg_thresh + $urandom_range(0, 2) - 1;
    if (v > 127) v = 127;
    return $urandom_range(0, 1) ? v : -v;
  endfunction

  task automatic queue_random_ticks(int n);
    int r;
    bit p;
    for (int k = 0; k < n; k++) begin
      gen_steer = next_stick(gen_steer);
      gen_thr   = next_stick(gen_thr);
      r = $urandom_range(0, 99);
      if (r < 70) gen_ms = gen_ms + $urandom_range(0, 40);
      else if (r < 85) gen_ms = gen_ms + $urandom_range(900, 1100);
      else if (r < 97) gen_ms = gen_ms + $urandom_range(1001, 5000);
      else gen_ms = $urandom;
      p = ($urandom_range(0, 99) < 85);
      queue_tick(gen_steer, gen_thr, p, gen_ms);
    end
  endtask

  task automatic wait_idle();
    while (ticks_pending_q.size() != 0 || s_axis_tvalid || lamps_expected_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    logic [2:0]  m;
    int          th;
    int          st;
    logic [31:0] lo;
    logic [31:0] hi;
    int          r;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed ticks under the reset settings
    queue_tick(0, 0, 1'b1, 32'h0000_0000);
    queue_tick(50, 80, 1'b1, 32'hFFFF_FFFF);
    queue_tick(-60, 80, 1'b1, 32'h0000_0014);
    queue_tick(5, 80, 1'b1, 32'h0000_0028);
    queue_tick(100, -100, 1'b1, 32'h0000_003C);
    queue_tick(-100, -100, 1'b1, 32'h0000_0050);
    queue_tick(-100, 127, 1'b1, 32'h0000_0064);
    queue_tick(127, 127, 1'b1, 32'h5555_5555);
    queue_tick(-128, -128, 1'b1, 32'hAAAA_AAAA);
    queue_tick(-128, -128, 1'b1, 32'h0000_0078);
    queue_tick(90, 90, 1'b0, 32'h0000_008C);
    queue_tick(90, -90, 1'b0, 32'h0000_00A0);
    queue_tick(10, 10, 1'b1, 32'h0000_00B4);
    queue_tick(11, -11, 1'b1, 32'h0000_00C8);
    queue_tick(-10, -11, 1'b1, 32'h0000_00DC);
    gen_ms = 32'h0000_00DC;
    queue_random_ticks(PHASE_TICKS);
    wait_idle();

    for (int ph = 1; ph < NUM_PHASES; ph++) begin
      if (ph < 8) m = ph[2:0] + 3'd1;
      else begin
        r = $urandom_range(0, 9);
        if (r < 3) m = MODE_STEER_MIX;
        else if (r < 5) m = MODE_THROTTLE;
        else if (r < 7) m = MODE_BREATH;
        else m = 3'($urandom_range(0, 7));
      end
      if (ph == 1) th = 0;
      else if (ph == 2) th = 100;
      else if (ph == 3) th = 127;
      else if ($urandom_range(0, 9) < 6) th = $urandom_range(5, 30);
      else th = $urandom_range(0, 127);
      if (ph == 4) st = 0;
      else if (ph == 5) st = 255;
      else if (ph == 6) st = 1;
      else if ($urandom_range(0, 9) < 7) st = $urandom_range(1, 40);
      else st = $urandom_range(0, 255);
      if (ph == 7) lo = 32'hFFFF_FFFF;
      else if (ph < 4 || $urandom_range(0, 4) == 0) lo = 32'h0;
      else lo = $urandom;
      if (ph == 9) hi = 32'h0;
      else if (ph < 4 || $urandom_range(0, 4) == 0) hi = 32'hFFFF_FFFF;
      else hi = $urandom;
      // breathing starts just short of the time wrap
      if (m == MODE_BREATH && !breath_on) gen_ms = 32'hFFFF_FE00;
      write_reg(CFG_MODE, {29'd0, m});
      write_reg(CFG_THRESHOLD, th);
      write_reg(CFG_FADE_STEP, st);
      write_reg(CFG_LOW_LEVELS, lo);
      write_reg(CFG_HIGH_LEVELS, hi);
      queue_random_ticks(PHASE_TICKS);
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0 && lamps_expected_q.size() == 0) begin
      $display("vehicle_light_level_controller_unit: match");
    end else begin
      $display("vehicle_light_level_controller_unit: mismatch");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/vllc_pkg.sv
sv/vllc_lamp.sv
sv/vehicle_light_level_controller_unit.sv
sim/tb_vehicle_light_level_controller_unit.sv
